// ----- src/sdce_pkg.sv -----
// Package for the SD card command engine: codes, constants and tables.
package sdce_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   localparam logic [2:0] FUNC_CMD   = 3'd0;
   localparam logic [2:0] FUNC_RESP  = 3'd1;
   localparam logic [2:0] FUNC_RDATA = 3'd2;
   localparam logic [2:0] FUNC_WDATA = 3'd3;
   localparam logic [2:0] FUNC_RESET = 3'd4;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_ERASE = 2'd3;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_READY    = 4'd1;
   localparam logic [3:0] ST_IDENT    = 4'd2;
   localparam logic [3:0] ST_STDBY    = 4'd3;
   localparam logic [3:0] ST_TRANS    = 4'd4;
   localparam logic [3:0] ST_SEND     = 4'd5;
   localparam logic [3:0] ST_RECV     = 4'd6;
   localparam logic [3:0] ST_PROG     = 4'd7;
   localparam logic [3:0] ST_DIS      = 4'd8;
   localparam logic [3:0] ST_INACTIVE = 4'd9;

   localparam int BIT_RANGE   = 31;
   localparam int BIT_CRC     = 23;
   localparam int BIT_ILLEGAL = 22;
   localparam int BIT_ERR     = 19;
   localparam int BIT_APP     = 5;

   localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
   localparam logic [5:0] CMD_ALL_CID    = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
   localparam logic [5:0] CMD_APP_SWIDTH = 6'd6;
   localparam logic [5:0] CMD_SELECT     = 6'd7;
   localparam logic [5:0] CMD_IF_COND    = 6'd8;
   localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
   localparam logic [5:0] CMD_SEND_CID   = 6'd10;
   localparam logic [5:0] CMD_STOP       = 6'd12;
   localparam logic [5:0] CMD_STATUS     = 6'd13;
   localparam logic [5:0] CMD_INACTIVE   = 6'd15;
   localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
   localparam logic [5:0] CMD_READ_ONE   = 6'd17;
   localparam logic [5:0] CMD_READ_MULTI = 6'd18;
   localparam logic [5:0] CMD_WRITE_ONE  = 6'd24;
   localparam logic [5:0] CMD_WRITE_MULT = 6'd25;
   localparam logic [5:0] CMD_ERASE_ST   = 6'd32;
   localparam logic [5:0] CMD_ERASE_END  = 6'd33;
   localparam logic [5:0] CMD_ERASE      = 6'd34;
   localparam logic [5:0] CMD_APP_OCR    = 6'd41;
   localparam logic [5:0] CMD_APP_SCR    = 6'd51;
   localparam logic [5:0] CMD_APP        = 6'd55;
   localparam logic [5:0] CMD_APP_OCR2   = 6'd58;

   localparam logic [31:0] OCR_WORD       = 32'hC0FF8000;
   localparam logic [31:0] STATUS_DEFAULT = 32'h00000100;
   localparam logic [31:0] STATUS_KEEP    = 32'hFFFF81FF;
   localparam logic [15:0] RCA_VALUE      = 16'h9001;
   localparam logic [25:0] CARD_BLOCKS_RST = 26'd524288;

   localparam logic [31:0] CID_W0 = 32'h42445345;
   localparam logic [31:0] CID_W1 = 32'h6D753239;
   localparam logic [31:0] CID_W2 = 32'h10000000;
   localparam logic [31:0] CID_W3 = 32'h0000F7FF;
   localparam logic [31:0] CSD_W0 = 32'h400E015A;
   localparam logic [31:0] CSD_W1 = 32'h5B99E000;
   localparam logic [31:0] CSD_W3 = 32'h026000FF;

   function automatic logic [7:0] scr_byte(input logic [2:0] idx);
      case (idx)
         3'd2:    scr_byte = 8'hA5;
         3'd3:    scr_byte = 8'h01;
         default: scr_byte = 8'h00;
      endcase
   endfunction

endpackage

// ----- src/sd_card_command_engine.sv -----
// SD card command engine: card-side command decode, status and data bookkeeping.
//
// One request in, one response out. A request is taken into an input register,
// decoded in a single pass of logic against the card state, and its response
// lands in an output register; a new request is accepted every cycle as long as
// the response side keeps taking results. Requests: tuser func (0 command, 1 read
// response word, 2 read data byte, 3 write data byte, 4 reset). Data reads and
// writes produce storage byte requests at the current byte offset; ERASE yields
// one range request. csr_wr_data sets card capacity in 512-byte sectors.
module sd_card_command_engine
   import sdce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [25:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [5:0] command_index, [37:6] argument, [45:38] write_byte
   input  logic [47:0]  req_tdata,
   // [2:0] func
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] resp_word, [39:32] data_byte, [80:40] storage_address,
   // [112:81] erase_last, [116:113] card_state
   output logic [119:0] rsp_tdata,
   // [0] data_byte_valid, [2:1] storage_op
   output logic [2:0]   rsp_tuser
);

   logic         in_valid_ff;
   logic [2:0]   in_func_ff;
   logic [5:0]   in_cmd_ff;
   logic [31:0]  in_arg_ff;
   logic [7:0]   in_wbyte_ff;
   logic         out_valid_ff;
   logic [119:0] out_data_ff;
   logic [2:0]   out_user_ff;
   logic         advance;

   logic [25:0]  card_blocks_ff;
   logic [3:0]   state_ff, state_in;
   logic [31:0]  status_ff, status_in;
   logic [31:0]  rw_ff [4];
   logic [31:0]  rw_in [4];
   logic [2:0]   ridx_ff, ridx_in;
   logic [15:0]  rca_ff, rca_in;
   logic [31:0]  blen_ff, blen_in;
   logic [31:0]  bcnt_ff, bcnt_in;
   logic         multi_ff, multi_in;
   logic [31:0]  es_ff, es_in;
   logic [31:0]  ee_ff, ee_in;
   logic         scr_ff, scr_in;
   logic [40:0]  boff_ff, boff_in;

   logic [31:0]  o_resp;
   logic [7:0]   o_byte;
   logic         o_bvalid;
   logic [1:0]   o_op;
   logic [40:0]  o_addr;
   logic [31:0]  o_elast;

   logic [34:0]  card_bytes;
   logic [40:0]  paddr;
   logic [31:0]  mul_prod;
   logic [21:0]  c_size;
   logic         addressed;
   logic [32:0]  erase_end;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   assign card_bytes = {card_blocks_ff, {SECTOR_SHIFT{1'b0}}};
   assign paddr      = {in_arg_ff, {SECTOR_SHIFT{1'b0}}};
   assign mul_prod   = in_arg_ff * blen_ff;
   assign c_size     = {6'd0, card_blocks_ff[25:10]} - 22'd1;
   assign addressed  = (state_ff >= ST_STDBY) && (state_ff <= ST_DIS);
   assign erase_end  = {1'b0, ee_ff} + {1'b0, blen_ff};

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      rw_in     = rw_ff;
      ridx_in   = ridx_ff;
      rca_in    = rca_ff;
      blen_in   = blen_ff;
      bcnt_in   = bcnt_ff;
      multi_in  = multi_ff;
      es_in     = es_ff;
      ee_in     = ee_ff;
      scr_in    = scr_ff;
      boff_in   = boff_ff;
      o_resp    = '0;
      o_byte    = '0;
      o_bvalid  = 1'b0;
      o_op      = OP_NONE;
      o_addr    = '0;
      o_elast   = '0;
      case (in_func_ff)
         FUNC_CMD: begin
            if (state_ff != ST_INACTIVE) begin
               status_in[BIT_ILLEGAL] = 1'b0;
               if (status_in[BIT_APP]) begin
                  case (in_cmd_ff)
                     CMD_APP_OCR, CMD_APP_OCR2: begin
                        ridx_in  = '0;
                        rw_in[0] = OCR_WORD;
                        if (state_in == ST_IDLE) state_in = ST_READY;
                     end
                     CMD_APP_SCR: begin
                        scr_in   = 1'b1;
                        multi_in = 1'b0;
                        bcnt_in  = '0;
                     end
                     CMD_STATUS, CMD_APP_SWIDTH: begin
                        status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                        ridx_in   = '0;
                        rw_in[0]  = status_in;
                        status_in[BIT_RANGE] = 1'b0;
                     end
                     CMD_APP: status_in[BIT_APP] = 1'b1;
                     default: status_in[BIT_APP] = 1'b0;
                  endcase
               end
               if (!status_in[BIT_APP]) begin
                  case (in_cmd_ff)
                     CMD_GO_IDLE: begin
                        state_in  = ST_IDLE;
                        blen_in   = 32'(SECTOR_BYTES);
                        ridx_in   = '0;
                        bcnt_in   = '0;
                        status_in = STATUS_DEFAULT;
                        multi_in  = 1'b0;
                        es_in     = '0;
                        ee_in     = '0;
                        scr_in    = 1'b0;
                        boff_in   = '0;
                     end
                     CMD_ALL_CID: begin
                        ridx_in  = '0;
                        rw_in[0] = CID_W0;
                        rw_in[1] = CID_W1;
                        rw_in[2] = CID_W2;
                        rw_in[3] = CID_W3;
                        state_in = ST_IDENT;
                     end
                     CMD_SEND_RCA: begin
                        rca_in = RCA_VALUE;
                        if (state_in == ST_IDENT) state_in = ST_STDBY;
                        ridx_in  = '0;
                        rw_in[0] = {RCA_VALUE, status_in[BIT_CRC], status_in[BIT_ILLEGAL],
                                    status_in[BIT_ERR], 1'b0, status_in[11:0]};
                     end
                     CMD_SELECT: begin
                        if (in_arg_ff[31:16] == rca_ff) begin
                           if (state_in == ST_STDBY || state_in == ST_DIS)
                              state_in = ST_TRANS;
                           else
                              status_in[BIT_ILLEGAL] = 1'b1;
                           status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                           ridx_in   = '0;
                           rw_in[0]  = status_in;
                           status_in[BIT_RANGE] = 1'b0;
                        end else if (state_in == ST_STDBY || state_in == ST_TRANS ||
                                     state_in == ST_SEND || state_in == ST_PROG) begin
                           state_in = ST_STDBY;
                        end else begin
                           status_in[BIT_ILLEGAL] = 1'b1;
                        end
                     end
                     CMD_SEND_CSD: begin
                        if (state_in == ST_STDBY) begin
                           ridx_in  = '0;
                           rw_in[0] = CSD_W0;
                           rw_in[1] = CSD_W1 | {26'd0, c_size[21:16]};
                           rw_in[2] = {c_size[15:0], 16'd0};
                           rw_in[3] = CSD_W3;
                        end else begin
                           status_in[BIT_ILLEGAL] = 1'b1;
                           status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                           ridx_in   = '0;
                           rw_in[0]  = status_in;
                           status_in[BIT_RANGE] = 1'b0;
                        end
                     end
                     CMD_SEND_CID: begin
                        if (state_in == ST_STDBY) begin
                           ridx_in  = '0;
                           rw_in[0] = CID_W0;
                           rw_in[1] = CID_W1;
                           rw_in[2] = CID_W2;
                           rw_in[3] = CID_W3;
                        end else begin
                           status_in[BIT_ILLEGAL] = 1'b1;
                        end
                     end
                     CMD_STOP: begin
                        if (state_in == ST_SEND || state_in == ST_RECV) begin
                           state_in  = ST_TRANS;
                           status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                           ridx_in   = '0;
                           rw_in[0]  = status_in;
                           status_in[BIT_RANGE] = 1'b0;
                        end else begin
                           status_in[BIT_ILLEGAL] = 1'b1;
                        end
                     end
                     CMD_STATUS: begin
                        if (addressed) begin
                           status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                           ridx_in   = '0;
                           rw_in[0]  = status_in;
                           status_in[BIT_RANGE] = 1'b0;
                        end else begin
                           status_in[BIT_ILLEGAL] = 1'b1;
                        end
                     end
                     CMD_INACTIVE: begin
                        if (addressed) state_in = ST_INACTIVE;
                        else status_in[BIT_ILLEGAL] = 1'b1;
                     end
                     CMD_BLOCKLEN: begin
                        if (state_in == ST_TRANS) blen_in = in_arg_ff;
                        else status_in[BIT_ILLEGAL] = 1'b1;
                        status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                        ridx_in   = '0;
                        rw_in[0]  = status_in;
                        status_in[BIT_RANGE] = 1'b0;
                     end
                     CMD_READ_ONE, CMD_READ_MULTI, CMD_WRITE_ONE, CMD_WRITE_MULT: begin
                        multi_in = (in_cmd_ff == CMD_READ_MULTI) ||
                                   (in_cmd_ff == CMD_WRITE_MULT);
                        if (state_in == ST_TRANS) begin
                           if (paddr >= {6'd0, card_bytes}) begin
                              status_in[BIT_RANGE] = 1'b1;
                           end else begin
                              boff_in  = paddr;
                              state_in = in_cmd_ff[3] ? ST_RECV : ST_SEND;
                              bcnt_in  = '0;
                           end
                        end else begin
                           status_in[BIT_ILLEGAL] = 1'b1;
                        end
                     end
                     CMD_ERASE_ST:  es_in = mul_prod;
                     CMD_ERASE_END: ee_in = mul_prod;
                     CMD_ERASE: begin
                        if (state_in == ST_TRANS) begin
                           if (es_ff <= ee_ff) begin
                              if ({2'd0, erase_end} > card_bytes) begin
                                 status_in[BIT_RANGE] = 1'b1;
                              end else begin
                                 o_op    = OP_ERASE;
                                 o_addr  = {9'd0, es_ff};
                                 o_elast = ee_ff;
                              end
                           end
                        end else begin
                           status_in[BIT_ILLEGAL] = 1'b1;
                        end
                        status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                        ridx_in   = '0;
                        rw_in[0]  = status_in;
                        status_in[BIT_RANGE] = 1'b0;
                     end
                     CMD_APP: status_in[BIT_APP] = 1'b1;
                     CMD_IF_COND: begin
                        ridx_in  = '0;
                        rw_in[0] = in_arg_ff;
                     end
                     default: begin
                        status_in[BIT_ILLEGAL] = 1'b1;
                        status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
                        ridx_in   = '0;
                        rw_in[0]  = status_in;
                        status_in[BIT_RANGE] = 1'b0;
                     end
                  endcase
               end
               status_in = (status_in & STATUS_KEEP) | {19'd0, state_in, 9'd0};
            end
         end
         FUNC_RESP: begin
            if (!ridx_ff[2]) begin
               o_resp  = rw_ff[ridx_ff[1:0]];
               ridx_in = ridx_ff + 3'd1;
            end
         end
         FUNC_RDATA: begin
            if (scr_ff) begin
               o_byte   = scr_byte(bcnt_ff[2:0]);
               o_bvalid = 1'b1;
               bcnt_in  = bcnt_ff + 32'd1;
               if (bcnt_in >= 32'd8) scr_in = 1'b0;
            end else if (state_ff == ST_SEND) begin
               if (boff_ff >= {6'd0, card_bytes}) begin
                  status_in[BIT_RANGE] = 1'b1;
               end else begin
                  o_op    = OP_READ;
                  o_addr  = boff_ff;
                  boff_in = boff_ff + 41'd1;
                  bcnt_in = bcnt_ff + 32'd1;
                  if (!multi_ff && bcnt_in >= blen_ff) state_in = ST_TRANS;
               end
            end
         end
         FUNC_WDATA: begin
            if (state_ff == ST_RECV) begin
               if (boff_ff >= {6'd0, card_bytes}) begin
                  status_in[BIT_RANGE] = 1'b1;
               end else begin
                  o_byte   = in_wbyte_ff;
                  o_bvalid = 1'b1;
                  o_op     = OP_WRITE;
                  o_addr   = boff_ff;
                  boff_in  = boff_ff + 41'd1;
                  bcnt_in  = bcnt_ff + 32'd1;
                  if (!multi_ff && bcnt_in >= blen_ff) state_in = ST_TRANS;
               end
            end
         end
         FUNC_RESET: begin
            state_in  = ST_IDLE;
            blen_in   = 32'(SECTOR_BYTES);
            ridx_in   = '0;
            bcnt_in   = '0;
            status_in = STATUS_DEFAULT;
            multi_in  = 1'b0;
            es_in     = '0;
            ee_in     = '0;
            scr_in    = 1'b0;
            boff_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff  <= req_tuser;
         in_cmd_ff   <= req_tdata[5:0];
         in_arg_ff   <= req_tdata[37:6];
         in_wbyte_ff <= req_tdata[45:38];
      end
      if (advance) begin
         rw_ff       <= rw_in;
         out_data_ff <= {3'd0, state_in, o_elast, o_addr, o_byte, o_resp};
         out_user_ff <= {o_op, o_bvalid};
      end
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         card_blocks_ff <= CARD_BLOCKS_RST;
         state_ff       <= ST_IDLE;
         status_ff      <= STATUS_DEFAULT;
         ridx_ff        <= '0;
         rca_ff         <= '0;
         blen_ff        <= 32'(SECTOR_BYTES);
         bcnt_ff        <= '0;
         multi_ff       <= 1'b0;
         es_ff          <= '0;
         ee_ff          <= '0;
         scr_ff         <= 1'b0;
         boff_ff        <= '0;
      end else begin
         if (csr_wr_en) card_blocks_ff <= csr_wr_data;
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
         if (advance) begin
            state_ff  <= state_in;
            status_ff <= status_in;
            ridx_ff   <= ridx_in;
            rca_ff    <= rca_in;
            blen_ff   <= blen_in;
            bcnt_ff   <= bcnt_in;
            multi_ff  <= multi_in;
            es_ff     <= es_in;
            ee_ff     <= ee_in;
            scr_ff    <= scr_in;
            boff_ff   <= boff_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_write_echo: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_user_ff[2:1] == OP_WRITE) |-> out_user_ff[0])
      else $error("write request without echoed byte");
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_user_ff[2:1] == OP_NONE) |-> (out_data_ff[112:40] == '0))
      else $error("address fields set without storage request");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("stalled response changed");
   a_state_move: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) |-> $stable(state_ff))
      else $error("card state moved without a request");
`endif

endmodule
